[rtl/core/pnos_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnos_pkg: shared types and constants
// Obstacle table sizes, field widths, operation codes and the request types
// passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package pnos_pkg;

	localparam int MaxObstacles = 30;
	localparam int IdxW  = 5;
	localparam int PosW  = 20;
	localparam int RadW  = 16;
	localparam int KindW = 3;
	localparam int DistW = 22;
	localparam int SqW   = 41;
	localparam int RootW = 21;

	typedef enum logic {
		OP_QUERY = 1'b0,
		OP_LOAD  = 1'b1
	} op_t;

	typedef struct packed {
		logic [MaxObstacles-1:0] mask;
		logic [PosW-1:0]         ax;
		logic [PosW-1:0]         ay;
	} query_t;

	typedef struct packed {
		logic              found;
		logic [IdxW-1:0]   idx;
		logic [KindW-1:0]  rank;
		logic [DistW-1:0]  surf_dist;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_DIFF,
		ST_SQ,
		ST_ROOT,
		ST_CMP,
		ST_DONE
	} back_state_t;

	function automatic logic [KindW-1:0] kind_rank(input logic [KindW-1:0] kind);
		kind_rank = (kind >= 3'd1 && kind <= 3'd4) ? kind : 3'd0;
	endfunction

endpackage

[rtl/core/pnos_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnos_in_if / pnos_out_if: valid-ready channels
// Input carries one load or query request, output one query result.
// ----------------------------------------------------------------------------
interface pnos_in_if;
	logic                              valid;
	logic                              ready;
	logic                              operation;
	logic [pnos_pkg::IdxW-1:0]         entry_index;
	logic [pnos_pkg::PosW-1:0]         entry_x;
	logic [pnos_pkg::PosW-1:0]         entry_y;
	logic [pnos_pkg::RadW-1:0]         entry_radius;
	logic [pnos_pkg::KindW-1:0]        entry_kind;
	logic [pnos_pkg::MaxObstacles-1:0] reach_mask;
	logic [pnos_pkg::PosW-1:0]         agent_x;
	logic [pnos_pkg::PosW-1:0]         agent_y;
	modport source (output valid, operation, entry_index, entry_x, entry_y, entry_radius,
		entry_kind, reach_mask, agent_x, agent_y, input ready);
	modport sink (input valid, operation, entry_index, entry_x, entry_y, entry_radius,
		entry_kind, reach_mask, agent_x, agent_y, output ready);
endinterface

interface pnos_out_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic [pnos_pkg::IdxW-1:0]         chosen_index;
	logic [pnos_pkg::KindW-1:0]        chosen_rank;
	logic signed [pnos_pkg::DistW-1:0] surface_distance;
	modport source (output valid, found, chosen_index, chosen_rank, surface_distance,
		input ready);
	modport sink (input valid, found, chosen_index, chosen_rank, surface_distance,
		output ready);
endinterface

[rtl/core/pnos_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnos_queue: two-entry query queue
// Decouples the front end from the scanning back end.
// ----------------------------------------------------------------------------
module pnos_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pnos_pkg::query_t   push_data,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output pnos_pkg::query_t   pop_data
);

	pnos_pkg::query_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	// store request
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (pop && !empty) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end

endmodule

[rtl/core/pnos_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnos_back: obstacle scan engine
// Walks the reach mask one set bit at a time, computes each surface distance
// with a bit-serial square root and keeps the best candidate.
// ----------------------------------------------------------------------------
module pnos_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  pnos_pkg::query_t                  q_data,
	output logic                              q_pop,
	output logic                              busy,
	input  logic [pnos_pkg::KindW-1:0]        kinds [pnos_pkg::MaxObstacles],
	output logic [pnos_pkg::IdxW-1:0]         rd_idx,
	input  logic [pnos_pkg::PosW-1:0]         rd_x,
	input  logic [pnos_pkg::PosW-1:0]         rd_y,
	input  logic [pnos_pkg::RadW-1:0]         rd_r,
	output logic                              res_valid,
	input  logic                              res_ready,
	output pnos_pkg::result_t                 res
);

	localparam int N = pnos_pkg::MaxObstacles;

	pnos_pkg::back_state_t state_q, state_d;
	logic [N-1:0]                  mask_q;
	logic [pnos_pkg::PosW-1:0]     ax_q, ay_q;
	logic [pnos_pkg::IdxW-1:0]     idx_q;
	logic [pnos_pkg::KindW-1:0]    rank_q;
	logic [pnos_pkg::PosW-1:0]     dx_q, dy_q;
	logic [pnos_pkg::SqW-1:0]      rem_q, root_q, bit_q;
	logic [pnos_pkg::RadW-1:0]     rad_q;
	logic                          found_q;
	logic [pnos_pkg::IdxW-1:0]     bidx_q;
	logic [pnos_pkg::KindW-1:0]    brank_q;
	logic signed [pnos_pkg::DistW-1:0] bdist_q;
	logic                          res_v_q;

	// lowest set bit of remaining mask
	logic [pnos_pkg::IdxW-1:0] low_idx;
	always_comb begin
		low_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (mask_q[i]) low_idx = pnos_pkg::IdxW'(i);
		end
	end

	logic [pnos_pkg::KindW-1:0] low_rank;
	assign low_rank = pnos_pkg::kind_rank(kinds[low_idx]);
	// address the table with the entry being picked so its data is ready in ST_DIFF
	assign rd_idx   = low_idx;
	assign q_pop    = (state_q == pnos_pkg::ST_IDLE) && !q_empty && !res_v_q;
	assign busy     = (state_q != pnos_pkg::ST_IDLE) || res_v_q;

	logic [pnos_pkg::SqW-1:0] trial;
	assign trial = root_q + bit_q;

	// square the absolute differences
	logic [2*pnos_pkg::PosW-1:0] sq_x, sq_y;
	assign sq_x = (2*pnos_pkg::PosW)'(dx_q) * (2*pnos_pkg::PosW)'(dx_q);
	assign sq_y = (2*pnos_pkg::PosW)'(dy_q) * (2*pnos_pkg::PosW)'(dy_q);

	logic signed [pnos_pkg::DistW-1:0] cand;
	assign cand = pnos_pkg::DistW'($signed({1'b0, root_q[pnos_pkg::RootW-1:0]})
		- $signed({2'b0, rad_q, 4'b0}));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pnos_pkg::ST_IDLE: if (q_pop) state_d = pnos_pkg::ST_PICK;
			pnos_pkg::ST_PICK: begin
				if (mask_q == '0) state_d = pnos_pkg::ST_DONE;
				else if (low_rank != 3'd0 && found_q && low_rank < brank_q)
					state_d = pnos_pkg::ST_DONE;
				else if (low_rank == 3'd0 && found_q && brank_q != 3'd0)
					state_d = pnos_pkg::ST_PICK;
				else state_d = pnos_pkg::ST_DIFF;
			end
			pnos_pkg::ST_DIFF: state_d = pnos_pkg::ST_SQ;
			pnos_pkg::ST_SQ:   state_d = pnos_pkg::ST_ROOT;
			pnos_pkg::ST_ROOT: if (bit_q == '0) state_d = pnos_pkg::ST_CMP;
			pnos_pkg::ST_CMP:  state_d = pnos_pkg::ST_PICK;
			pnos_pkg::ST_DONE: state_d = pnos_pkg::ST_IDLE;
			default: state_d = pnos_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnos_pkg::ST_IDLE;
			res_v_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_v_q && res_ready) res_v_q <= 1'b0;
			if (state_q == pnos_pkg::ST_IDLE && q_pop) found_q <= 1'b0;
			if (state_q == pnos_pkg::ST_CMP && (!found_q || rank_q > brank_q
				|| cand < bdist_q)) found_q <= 1'b1;
			if (state_q == pnos_pkg::ST_DONE) res_v_q <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			pnos_pkg::ST_IDLE: if (q_pop) begin
				mask_q <= q_data.mask;
				ax_q   <= q_data.ax;
				ay_q   <= q_data.ay;
			end
			pnos_pkg::ST_PICK: if (mask_q != '0) begin
				mask_q[low_idx] <= 1'b0;
				idx_q  <= low_idx;
				rank_q <= low_rank;
			end
			pnos_pkg::ST_DIFF: begin
				dx_q  <= (rd_x >= ax_q) ? rd_x - ax_q : ax_q - rd_x;
				dy_q  <= (rd_y >= ay_q) ? rd_y - ay_q : ay_q - rd_y;
				rad_q <= rd_r;
			end
			pnos_pkg::ST_SQ: begin
				rem_q  <= pnos_pkg::SqW'(sq_x) + pnos_pkg::SqW'(sq_y);
				root_q <= '0;
				bit_q  <= pnos_pkg::SqW'(1) << 40;
			end
			pnos_pkg::ST_ROOT: if (bit_q != '0) begin
				if (rem_q >= trial) begin
					rem_q  <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			pnos_pkg::ST_CMP: if (!found_q || rank_q > brank_q || cand < bdist_q) begin
				bidx_q  <= idx_q;
				brank_q <= rank_q;
				bdist_q <= cand;
			end
			default: ;
		endcase
	end

	assign res_valid     = res_v_q;
	assign res.found     = found_q;
	assign res.idx       = found_q ? bidx_q : '0;
	assign res.rank      = found_q ? brank_q : '0;
	assign res.surf_dist = found_q ? bdist_q : '0;

endmodule

[rtl/core/pnos_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnos_front: request intake and obstacle table
// Writes load requests into the table and passes queries to the queue.
// ----------------------------------------------------------------------------
module pnos_front (
	input  logic                              clk,
	input  logic                              arst_n,
	pnos_in_if.sink                           in_ch,
	input  logic                              q_full,
	input  logic                              busy,
	output logic                              q_push,
	output pnos_pkg::query_t                  q_data,
	output logic [pnos_pkg::KindW-1:0]        kinds [pnos_pkg::MaxObstacles],
	input  logic [pnos_pkg::IdxW-1:0]         rd_idx,
	output logic [pnos_pkg::PosW-1:0]         rd_x,
	output logic [pnos_pkg::PosW-1:0]         rd_y,
	output logic [pnos_pkg::RadW-1:0]         rd_r
);

	logic [pnos_pkg::PosW-1:0]  x_q [pnos_pkg::MaxObstacles];
	logic [pnos_pkg::PosW-1:0]  y_q [pnos_pkg::MaxObstacles];
	logic [pnos_pkg::RadW-1:0]  r_q [pnos_pkg::MaxObstacles];
	logic [pnos_pkg::KindW-1:0] kind_q [pnos_pkg::MaxObstacles];
	logic load;

	// hold loads until every earlier query has been answered
	assign in_ch.ready = !q_full && !(busy && in_ch.operation == pnos_pkg::OP_LOAD);
	assign load   = in_ch.valid && in_ch.ready && (in_ch.operation == pnos_pkg::OP_LOAD)
		&& (in_ch.entry_index < pnos_pkg::IdxW'(pnos_pkg::MaxObstacles));
	assign q_push = in_ch.valid && in_ch.ready && (in_ch.operation == pnos_pkg::OP_QUERY);
	assign q_data = '{mask: in_ch.reach_mask, ax: in_ch.agent_x, ay: in_ch.agent_y};
	assign kinds  = kind_q;

	// table store, registered read port
	always_ff @(posedge clk) begin
		if (load) begin
			x_q[in_ch.entry_index] <= in_ch.entry_x;
			y_q[in_ch.entry_index] <= in_ch.entry_y;
			r_q[in_ch.entry_index] <= in_ch.entry_radius;
		end
		rd_x <= x_q[rd_idx];
		rd_y <= y_q[rd_idx];
		rd_r <= r_q[rd_idx];
	end

	// kind table clears at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pnos_pkg::MaxObstacles; i++) kind_q[i] <= '0;
		end else if (load) begin
			kind_q[in_ch.entry_index] <= in_ch.entry_kind;
		end
	end

endmodule

[rtl/core/priority_nearest_obstacle_select_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_nearest_obstacle_select_core: obstacle selector
// Picks one obstacle among those in reach, by type rank then distance.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests. A load (operation 1) to an index below 30 writes
//   one table entry in the cycle it is accepted and gives no result. A load
//   waits (in_ch.ready low) while any query is queued, scanning or holding
//   its result. A query (operation 0) enters a two-deep queue and yields one
//   result. The back end scans set reach bits from index 0 upward. Each
//   visited obstacle passes through pick (with the registered table read),
//   difference, square, 21 square-root steps and a compare; the bit-serial
//   root dominates the time a query takes. Skipped untyped entries go
//   straight back to pick. The result waits in an output register; while it
//   is not taken, the queue still accepts queries until full, then
//   in_ch.ready drops. Reset clears the kind table (all untyped), the queue
//   and the scanner.
// ----------------------------------------------------------------------------
module priority_nearest_obstacle_select_core (
	input  logic       clk,
	input  logic       arst_n,
	pnos_in_if.sink    in_ch,
	pnos_out_if.source out_ch
);

	logic q_full, q_push, q_pop, q_empty;
	logic back_busy, scan_busy;
	pnos_pkg::query_t  q_in, q_out;
	pnos_pkg::result_t res;
	logic [pnos_pkg::KindW-1:0] kinds [pnos_pkg::MaxObstacles];
	logic [pnos_pkg::IdxW-1:0]  rd_idx;
	logic [pnos_pkg::PosW-1:0]  rd_x, rd_y;
	logic [pnos_pkg::RadW-1:0]  rd_r;

	// any query still queued or in the back end
	assign scan_busy = !q_empty || back_busy;

	pnos_front u_front (.clk, .arst_n, .in_ch, .q_full, .busy(scan_busy), .q_push,
		.q_data(q_in), .kinds, .rd_idx, .rd_x, .rd_y, .rd_r);

	pnos_queue u_queue (.clk, .arst_n, .push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_data(q_out));

	pnos_back u_back (.clk, .arst_n, .q_empty, .q_data(q_out), .q_pop, .busy(back_busy),
		.kinds, .rd_idx, .rd_x, .rd_y, .rd_r, .res_valid(out_ch.valid),
		.res_ready(out_ch.ready), .res);

	assign out_ch.found            = res.found;
	assign out_ch.chosen_index     = res.idx;
	assign out_ch.chosen_rank      = res.rank;
	assign out_ch.surface_distance = res.surf_dist;

endmodule

[tb/pnos_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnos_checker: obstacle selector scoreboard
// Watches both channels. It mirrors the obstacle table from accepted loads,
// predicts each query result and compares returned results in order.
// ----------------------------------------------------------------------------
module pnos_checker (
	input  logic        clk,
	input  logic        arst_n,
	pnos_in_if          in_ch,
	pnos_out_if         out_ch,
	output int unsigned mismatches,
	output int unsigned pending
);

	logic [pnos_pkg::PosW-1:0]  obs_x    [pnos_pkg::MaxObstacles];
	logic [pnos_pkg::PosW-1:0]  obs_y    [pnos_pkg::MaxObstacles];
	logic [pnos_pkg::RadW-1:0]  obs_rad  [pnos_pkg::MaxObstacles];
	logic [pnos_pkg::KindW-1:0] obs_kind [pnos_pkg::MaxObstacles];
	pnos_pkg::result_t          expected_results[$];

	// floor of the square root, one result bit per pass
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned rem, root, bit_w;
		rem = v;
		root = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > rem)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (rem >= root + bit_w) begin
				rem -= root + bit_w;
				root = (root >> 1) + bit_w;
			end else begin
				root >>= 1;
			end
			bit_w >>= 2;
		end
		return root;
	endfunction

	function automatic logic [2:0] rank_of(input logic [pnos_pkg::KindW-1:0] kind);
		return (kind >= 1 && kind <= 4) ? kind : 3'd0;
	endfunction

	// scan reach bits upward: best rank, then nearest surface, lower index on ties
	function automatic pnos_pkg::result_t pick_obstacle(
		input logic [pnos_pkg::MaxObstacles-1:0] mask,
		input logic [pnos_pkg::PosW-1:0] ax, input logic [pnos_pkg::PosW-1:0] ay);
		pnos_pkg::result_t r;
		bit hit;
		logic [2:0] best_rank, rk;
		int best_idx;
		longint best_d, d, dx, dy;
		hit = 0;
		best_rank = 0;
		best_idx = 0;
		best_d = 0;
		for (int i = 0; i < pnos_pkg::MaxObstacles; i++) begin
			if (mask[i]) begin
				rk = rank_of(obs_kind[i]);
				if (rk != 0 && hit && rk < best_rank)
					break;
				if (!(rk == 0 && hit && best_rank != 0)) begin
					dx = longint'(obs_x[i]) - longint'(ax);
					dy = longint'(obs_y[i]) - longint'(ay);
					d = longint'(floor_root(dx * dx + dy * dy))
						- longint'(obs_rad[i]) * 16;
					if (!hit || rk > best_rank || d < best_d) begin
						hit = 1;
						best_rank = rk;
						best_idx = i;
						best_d = d;
					end
				end
			end
		end
		r.found = hit;
		r.idx = hit ? best_idx[pnos_pkg::IdxW-1:0] : '0;
		r.rank = hit ? best_rank : '0;
		r.surf_dist = hit ? best_d[pnos_pkg::DistW-1:0] : '0;
		return r;
	endfunction

	task automatic report(input string what, input pnos_pkg::result_t exp_r,
		input pnos_pkg::result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t: %s: expected found=%0d idx=%0d rank=%0d dist=%0d, ",
				"got found=%0d idx=%0d rank=%0d dist=%0d"},
				$realtime, what, exp_r.found, exp_r.idx, exp_r.rank,
				$signed(exp_r.surf_dist), got.found, got.idx, got.rank,
				$signed(got.surf_dist));
	endtask

	// track loads, predict queries, compare results
	always @(posedge clk or negedge arst_n) begin
		pnos_pkg::result_t got, exp_r;
		if (!arst_n) begin
			for (int i = 0; i < pnos_pkg::MaxObstacles; i++)
				obs_kind[i] <= '0;
			expected_results.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.operation == pnos_pkg::OP_LOAD) begin
					if (in_ch.entry_index < pnos_pkg::MaxObstacles) begin
						obs_x[in_ch.entry_index]    <= in_ch.entry_x;
						obs_y[in_ch.entry_index]    <= in_ch.entry_y;
						obs_rad[in_ch.entry_index]  <= in_ch.entry_radius;
						obs_kind[in_ch.entry_index] <= in_ch.entry_kind;
					end
				end else begin
					expected_results.push_back(pick_obstacle(in_ch.reach_mask,
						in_ch.agent_x, in_ch.agent_y));
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				got.found = out_ch.found;
				got.idx = out_ch.chosen_index;
				got.rank = out_ch.chosen_rank;
				got.surf_dist = out_ch.surface_distance;
				if (expected_results.size() == 0) begin
					report("unexpected result", '0, got);
				end else begin
					exp_r = expected_results.pop_front();
					if (got.found !== exp_r.found || got.idx !== exp_r.idx ||
						got.rank !== exp_r.rank || got.surf_dist !== exp_r.surf_dist)
						report("result mismatch", exp_r, got);
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: obstacle selector testbench
// Drives loads and queries with random gaps and result stalls. Directed
// requests cover ties, rank order, early stop and untyped entries; random
// requests only reach entries that were loaded before.
// ----------------------------------------------------------------------------
module tb;

	localparam int IdleLimit = 20000;

	logic clk = 0;
	logic arst_n = 0;
	int unsigned mismatches, pending;
	int unsigned idle_cycles = 0;
	bit in_burst = 0, out_burst = 0;
	logic [pnos_pkg::MaxObstacles-1:0] loaded = '0;

	pnos_in_if  in_ch ();
	pnos_out_if out_ch ();

	priority_nearest_obstacle_select_core DUT (.clk(clk), .arst_n(arst_n),
		.in_ch(in_ch), .out_ch(out_ch));

	pnos_checker u_checker (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.mismatches(mismatches), .pending(pending));

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// end the run when no request or result moves for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// result side: random stalls, with bursts of none
	initial begin
		int stall;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			stall = out_burst ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				@(posedge clk);
				out_ch.ready <= 0;
				repeat (stall - 1) @(posedge clk);
			end
			@(posedge clk);
			out_ch.ready <= 1;
			do @(negedge clk); while (!out_ch.valid);
			if ($urandom_range(0, 99) == 0)
				out_burst = !out_burst;
		end
	end

	// send one request: optional gap, then hold until accepted
	task automatic send(input pnos_pkg::op_t op, input logic [pnos_pkg::IdxW-1:0] idx,
		input logic [pnos_pkg::PosW-1:0] ex, input logic [pnos_pkg::PosW-1:0] ey,
		input logic [pnos_pkg::RadW-1:0] rad, input logic [pnos_pkg::KindW-1:0] kind,
		input logic [pnos_pkg::MaxObstacles-1:0] mask,
		input logic [pnos_pkg::PosW-1:0] ax, input logic [pnos_pkg::PosW-1:0] ay);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.operation <= op;
		in_ch.entry_index <= idx;
		in_ch.entry_x <= ex;
		in_ch.entry_y <= ey;
		in_ch.entry_radius <= rad;
		in_ch.entry_kind <= kind;
		in_ch.reach_mask <= mask;
		in_ch.agent_x <= ax;
		in_ch.agent_y <= ay;
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
		if (op == pnos_pkg::OP_LOAD && idx < pnos_pkg::MaxObstacles)
			loaded[idx] = 1'b1;
	endtask

	task automatic load(input logic [pnos_pkg::IdxW-1:0] idx,
		input logic [pnos_pkg::PosW-1:0] ex, input logic [pnos_pkg::PosW-1:0] ey,
		input logic [pnos_pkg::RadW-1:0] rad, input logic [pnos_pkg::KindW-1:0] kind);
		send(pnos_pkg::OP_LOAD, idx, ex, ey, rad, kind,
			pnos_pkg::MaxObstacles'($urandom), pnos_pkg::PosW'($urandom),
			pnos_pkg::PosW'($urandom));
	endtask

	task automatic query(input logic [pnos_pkg::MaxObstacles-1:0] mask,
		input logic [pnos_pkg::PosW-1:0] ax, input logic [pnos_pkg::PosW-1:0] ay);
		send(pnos_pkg::OP_QUERY, pnos_pkg::IdxW'($urandom), pnos_pkg::PosW'($urandom),
			pnos_pkg::PosW'($urandom), pnos_pkg::RadW'($urandom),
			pnos_pkg::KindW'($urandom), mask & loaded, ax, ay);
	endtask

	// positions: corners, a small cluster for ties, or anywhere
	function automatic logic [pnos_pkg::PosW-1:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return ($urandom_range(0, 1) != 0) ? '1 : '0;
			1: return pnos_pkg::PosW'($urandom_range(0, 3) * 16);
			default: return pnos_pkg::PosW'($urandom);
		endcase
	endfunction

	function automatic logic [pnos_pkg::MaxObstacles-1:0] rand_mask();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return pnos_pkg::MaxObstacles'($urandom & $urandom & $urandom);
			2: return ($urandom_range(0, 9) == 0) ? '0
				: (pnos_pkg::MaxObstacles'(1) << $urandom_range(0, 29));
			default: return pnos_pkg::MaxObstacles'($urandom);
		endcase
	endfunction

	initial begin
		in_ch.valid = 0;
		in_ch.operation = pnos_pkg::OP_QUERY;
		in_ch.entry_index = '0;
		in_ch.entry_x = '0;
		in_ch.entry_y = '0;
		in_ch.entry_radius = '0;
		in_ch.entry_kind = '0;
		in_ch.reach_mask = '0;
		in_ch.agent_x = '0;
		in_ch.agent_y = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: nothing found, ties, rank order, early stop, untyped, ignored load
		query('0, '0, '0);
		load(5'd0, '0, '0, '0, 3'd4);
		load(5'd1, '0, '0, '0, 3'd4);
		load(5'd2, '1, '1, '1, 3'd3);
		load(5'd3, 20'd160, 20'd0, 16'd2, 3'd0);
		load(5'd4, 20'd0, 20'd16, 16'd0, 3'd7);
		load(5'd5, '1, '0, 16'd5, 3'd1);
		load(5'd6, '0, '1, '0, 3'd2);
		load(5'd31, '1, '1, '1, 3'd4);
		load(5'd30, '1, '1, '1, 3'd4);
		query(30'h3, '0, '0);
		query(30'h5, '1, '1);
		query(30'h5, '0, '0);
		query(30'h6, '1, '1);
		query(30'h18, '0, '0);
		query(30'h18, '1, '1);
		query(30'h7F, '1, '0);
		query(30'h60, '0, '1);
		query(30'h78, 20'd80, 20'd80);

		// random: loads keep the table changing, queries look only at loaded entries
		for (int n = 0; n < 1300; n++) begin
			if (n == 650) begin
				in_ch.valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if ($urandom_range(0, 149) == 0)
				in_burst = !in_burst;
			if ($urandom_range(0, 9) < 3 || loaded == '0)
				load(($urandom_range(0, 19) == 0) ? pnos_pkg::IdxW'($urandom_range(30, 31))
						: pnos_pkg::IdxW'($urandom_range(0, 29)),
					rand_pos(), rand_pos(),
					($urandom_range(0, 3) == 0) ? 16'hFFFF
						: pnos_pkg::RadW'($urandom_range(0, 300)),
					pnos_pkg::KindW'($urandom_range(0, 7)));
			else
				query(rand_mask(), rand_pos(), rand_pos());
		end
		in_ch.valid <= 0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

[files.f]
rtl/core/pnos_pkg.sv
rtl/core/pnos_if.sv
rtl/core/pnos_queue.sv
rtl/core/pnos_back.sv
rtl/core/pnos_front.sv
rtl/core/priority_nearest_obstacle_select_core.sv
tb/pnos_checker.sv
tb/tb.sv
